[src/lhap_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhap_pkg
// Shared types, constants and the CRC-16/ARC byte step for the LHA member
// header parser.
// ----------------------------------------------------------------------------
package lhap_pkg;

   localparam int FRONT_BYTES = 32;
   localparam int FB_IDX_W    = $clog2(FRONT_BYTES);
   localparam int POS_W       = 34;

   localparam int BQ_DEPTH    = 4;
   localparam int BQ_PTR_W    = $clog2(BQ_DEPTH);
   localparam int RQ_DEPTH    = 2;
   localparam int RQ_PTR_W    = $clog2(RQ_DEPTH);

   localparam logic [23:0] CODE_STORED = 24'h6c6830;
   localparam logic [23:0] CODE_DIR    = 24'h6c6864;
   localparam logic [7:0]  DELIM       = 8'h2d;
   localparam int          MIN_MEMBER  = 21;
   localparam int          L3_FIX_BYTE = 27;

   localparam logic [POS_W-1:0]    DECIDE_POS   = POS_W'(MIN_MEMBER - 1);
   localparam logic [POS_W-1:0]    L3_FIX_POS   = POS_W'(L3_FIX_BYTE);
   localparam logic [FB_IDX_W-1:0] REPLAY_HDR   = FB_IDX_W'(MIN_MEMBER - 2);
   localparam logic [FB_IDX_W-1:0] REPLAY_L3    = FB_IDX_W'(L3_FIX_BYTE - 1);

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_LHA   = 3'd1;
   localparam logic [2:0] ST_BAD_LEVEL = 3'd2;
   localparam logic [2:0] ST_BAD_WORD  = 3'd3;
   localparam logic [2:0] ST_EXT_CHAIN = 3'd4;

   localparam logic [1:0] CR_NONE     = 2'd0;
   localparam logic [1:0] CR_MATCH    = 2'd1;
   localparam logic [1:0] CR_MISMATCH = 2'd2;

   localparam logic [1:0] LVL_0 = 2'd0;
   localparam logic [1:0] LVL_1 = 2'd1;
   localparam logic [1:0] LVL_2 = 2'd2;
   localparam logic [1:0] LVL_3 = 2'd3;

   typedef enum logic [3:0] {
      CH_IDLE = 4'b0001,
      CH_WALK = 4'b0010,
      CH_DONE = 4'b0100,
      CH_ERR  = 4'b1000
   } chain_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  header_level;
      logic [23:0] method_code;
      logic        is_directory;
      logic        is_compressed;
      logic [31:0] compressed_size;
      logic [31:0] original_size;
      logic [15:0] stored_crc;
      logic [7:0]  os_identifier;
      logic [31:0] data_offset;
      logic [31:0] member_size;
      logic [1:0]  crc_result;
   } res_type;

   // Reflected polynomial 0xA001, one byte per call.
   function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc_prev,
                                                  input logic [7:0]  data);
      logic [15:0] c;
      c = crc_prev ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[src/lhap_byte_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhap_byte_queue
// Front queue that takes archive bytes and holds them for the member engine.
// ----------------------------------------------------------------------------
module lhap_byte_queue (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] push_data,
   output logic       full,
   input  logic       pop,
   output logic       empty,
   output logic [7:0] head
);
   import lhap_pkg::*;

   logic [7:0]          mem_ff [BQ_DEPTH];
   logic [BQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [BQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [BQ_PTR_W:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (BQ_PTR_W+1)'(BQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/lhap_result_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhap_result_queue
// Output queue holding finished member results until they are taken.
// ----------------------------------------------------------------------------
module lhap_result_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lhap_pkg::res_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output lhap_pkg::res_type head
);
   import lhap_pkg::*;

   res_type             mem_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RQ_PTR_W:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (RQ_PTR_W+1)'(RQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/lhap_member_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhap_member_engine
// Back end: walks each member byte by byte, decodes the header, follows the
// extended-header chain, keeps the data CRC and builds one result per member.
// ----------------------------------------------------------------------------
module lhap_member_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              in_empty,
   input  logic [7:0]        in_byte,
   output logic              in_pop,
   input  logic              res_full,
   output logic              res_push,
   output lhap_pkg::res_type res_data
);
   import lhap_pkg::*;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                phase_ff, phase_in;
   logic [7:0]          buf_ff [FRONT_BYTES];
   logic [7:0]          buf_in [FRONT_BYTES];
   logic [1:0]          level_ff, level_in;
   logic [23:0]         method_ff, method_in;
   logic [31:0]         hs_ff, hs_in;
   logic [31:0]         ds_ff, ds_in;
   logic [POS_W-1:0]    ext_next_ff, ext_next_in;
   logic [31:0]         consumed_ff, consumed_in;
   logic [7:0]          acc_ff, acc_in;
   logic [15:0]         crc_ff, crc_in;
   logic                first_ff, first_in;
   logic                halted_ff, halted_in;
   logic [7:0]          name_len_ff, name_len_in;
   chain_type           chain_ff, chain_in;
   logic [15:0]         crc_held_ff, crc_held_in;
   logic [7:0]          os_ff, os_in;
   logic                known_ff, known_in;
   logic [POS_W-1:0]    lo_ff, lo_in;
   logic [POS_W-1:0]    hi_ff, hi_in;
   logic [POS_W-1:0]    bound_ff, bound_in;
   logic [POS_W-1:0]    total_ff, total_in;
   logic                l3_fixed_ff, l3_fixed_in;
   logic                replay_ff, replay_in;
   logic [FB_IDX_W-1:0] ridx_ff, ridx_in;
   logic [FB_IDX_W-1:0] rlast_ff, rlast_in;
   logic                check_ff;

   logic                proc_en, proc_real, real_step;
   logic [POS_W-1:0]    pq;
   logic [7:0]          pb;
   logic [15:0]         c_s;
   logic [POS_W-1:0]    c_pos, c_sum, c_start;
   logic [POS_W-1:0]    last_hdr;
   logic                chain_bad, is_stored, is_dir;
   logic [15:0]         hdr_crc;
   logic [31:0]         hs_dec;

   always_comb begin
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      buf_in      = buf_ff;
      level_in    = level_ff;
      method_in   = method_ff;
      hs_in       = hs_ff;
      ds_in       = ds_ff;
      ext_next_in = ext_next_ff;
      consumed_in = consumed_ff;
      acc_in      = acc_ff;
      crc_in      = crc_ff;
      first_in    = first_ff;
      halted_in   = halted_ff;
      name_len_in = name_len_ff;
      chain_in    = chain_ff;
      crc_held_in = crc_held_ff;
      os_in       = os_ff;
      known_in    = known_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      bound_in    = bound_ff;
      total_in    = total_ff;
      l3_fixed_in = l3_fixed_ff;
      replay_in   = replay_ff;
      ridx_in     = ridx_ff;
      rlast_in    = rlast_ff;
      in_pop      = 1'b0;
      res_push    = 1'b0;
      res_data    = '0;
      proc_en     = 1'b0;
      proc_real   = 1'b0;
      real_step   = 1'b0;
      pq          = pos_ff;
      pb          = in_byte;
      c_s         = '0;
      c_pos       = '0;
      c_sum       = '0;
      c_start     = '0;
      last_hdr    = '0;
      chain_bad   = 1'b0;
      is_stored   = 1'b0;
      is_dir      = 1'b0;
      hdr_crc     = '0;
      hs_dec      = '0;

      if (replay_ff) begin
         // Re-run the header bytes already seen through the CRC and extended-header walker.
         proc_en = 1'b1;
         pq      = POS_W'(ridx_ff);
         pb      = buf_ff[ridx_ff];
         ridx_in = ridx_ff + 1'b1;
         if (ridx_ff == rlast_ff) replay_in = 1'b0;
      end else if (!in_empty && halted_ff) begin
         in_pop = 1'b1;
      end else if (!in_empty && !res_full) begin
         if (pos_ff[POS_W-1:FB_IDX_W] == '0) buf_in[pos_ff[FB_IDX_W-1:0]] = in_byte;
         if (!phase_ff) begin
            if (pos_ff < DECIDE_POS) begin
               pos_in = pos_ff + 1'b1;
               in_pop = 1'b1;
            end else if (buf_in[2] != DELIM || buf_in[6] != DELIM) begin
               in_pop    = 1'b1;
               halted_in = 1'b1;
               if (first_ff) begin
                  res_push        = 1'b1;
                  res_data.status = ST_NOT_LHA;
               end
            end else if (in_byte > 8'd3) begin
               in_pop               = 1'b1;
               halted_in            = 1'b1;
               res_push             = 1'b1;
               res_data.status      = ST_BAD_LEVEL;
               res_data.method_code = {buf_in[3], buf_in[4], buf_in[5]};
            end else if (in_byte[1:0] == LVL_3 && {buf_in[1], buf_in[0]} != 16'd4) begin
               in_pop                = 1'b1;
               halted_in             = 1'b1;
               res_push              = 1'b1;
               res_data.status       = ST_BAD_WORD;
               res_data.header_level = LVL_3;
               res_data.method_code  = {buf_in[3], buf_in[4], buf_in[5]};
            end else begin
               // Header accepted: the byte stays at the head until the replay is done.
               method_in = {buf_in[3], buf_in[4], buf_in[5]};
               level_in  = in_byte[1:0];
               ds_in     = {buf_in[10], buf_in[9], buf_in[8], buf_in[7]};
               unique case (in_byte[1:0])
                  LVL_0, LVL_1: hs_dec = {24'd0, buf_in[0]};
                  LVL_2:        hs_dec = {16'd0, buf_in[1], buf_in[0]};
                  default:      hs_dec = '0;
               endcase
               hs_in = hs_dec;
               unique case (in_byte[1:0])
                  LVL_0: begin
                     known_in = 1'b1;
                     lo_in    = POS_W'(hs_dec) + POS_W'(2);
                     hi_in    = POS_W'(hs_dec) + POS_W'(2) + POS_W'(ds_in);
                     total_in = POS_W'(hs_dec) + POS_W'(2) + POS_W'(ds_in);
                  end
                  LVL_1: begin
                     chain_in    = CH_WALK;
                     ext_next_in = POS_W'(hs_dec);
                     bound_in    = POS_W'(hs_dec) + POS_W'(2) + POS_W'(ds_in);
                     total_in    = POS_W'(hs_dec) + POS_W'(2) + POS_W'(ds_in);
                  end
                  LVL_2: begin
                     known_in = 1'b1;
                     lo_in    = POS_W'(hs_dec);
                     hi_in    = POS_W'(hs_dec) + POS_W'(ds_in);
                     total_in = POS_W'(hs_dec) + POS_W'(ds_in);
                  end
                  default: begin
                     total_in = POS_W'(ds_in);
                  end
               endcase
               phase_in  = 1'b1;
               replay_in = 1'b1;
               ridx_in   = '0;
               rlast_in  = REPLAY_HDR;
            end
         end else if (level_ff == LVL_3 && pos_ff == L3_FIX_POS && !l3_fixed_ff) begin
            // Level 3 header size becomes known here; bytes before it are replayed.
            hs_in       = {in_byte, buf_ff[26], buf_ff[25], buf_ff[24]};
            known_in    = 1'b1;
            lo_in       = POS_W'(hs_in);
            hi_in       = POS_W'(hs_in) + POS_W'(ds_ff);
            total_in    = POS_W'(hs_in) + POS_W'(ds_ff);
            l3_fixed_in = 1'b1;
            replay_in   = 1'b1;
            ridx_in     = '0;
            rlast_in    = REPLAY_L3;
         end else begin
            in_pop    = 1'b1;
            proc_en   = 1'b1;
            proc_real = 1'b1;
            real_step = 1'b1;
         end
      end

      if (proc_en) begin
         if (known_ff && pq >= lo_ff && pq < hi_ff) crc_in = crc16_arc_byte(crc_ff, pb);
         if (proc_real && level_ff <= LVL_1) begin
            if (pq == POS_W'(21)) begin
               name_len_in = pb;
            end else if (pq > POS_W'(21)) begin
               if (pq == POS_W'(22) + POS_W'(name_len_ff)) begin
                  crc_held_in = {crc_held_ff[15:8], pb};
               end else if (pq == POS_W'(23) + POS_W'(name_len_ff)) begin
                  crc_held_in = {pb, crc_held_ff[7:0]};
               end else if (level_ff == LVL_1 && pq == POS_W'(24) + POS_W'(name_len_ff)) begin
                  os_in = pb;
               end
            end
         end
         if (level_ff == LVL_1 && chain_ff == CH_WALK) begin
            if (pq == ext_next_ff) begin
               acc_in = pb;
            end else if (pq == ext_next_ff + 1'b1) begin
               c_s     = {pb, acc_ff};
               c_pos   = pq + 1'b1;
               c_start = POS_W'(hs_ff) + POS_W'(2);
               c_sum   = c_pos + POS_W'(c_s);
               if (c_s == '0) begin
                  chain_in    = CH_DONE;
                  consumed_in = 32'(c_pos - c_start);
                  known_in    = 1'b1;
                  lo_in       = c_pos;
                  hi_in       = bound_ff;
               end else if (c_s < 16'd2 || c_sum > bound_ff) begin
                  chain_in = CH_ERR;
               end else begin
                  ext_next_in = c_sum - POS_W'(2);
               end
            end
         end
      end

      if (real_step) begin
         unique case (level_ff)
            LVL_0:   last_hdr = POS_W'(23) + POS_W'(name_len_ff);
            LVL_1:   last_hdr = POS_W'(24) + POS_W'(name_len_ff);
            LVL_2:   last_hdr = POS_W'(23);
            default: last_hdr = L3_FIX_POS;
         endcase
         if (pos_ff >= last_hdr &&
             ({1'b0, pos_ff} + 1'b1) >= {1'b0, total_ff} &&
             !(level_ff == LVL_1 && chain_in == CH_WALK)) begin
            chain_bad = (level_ff == LVL_1) && (chain_in != CH_DONE);
            is_stored = (method_ff == CODE_STORED);
            is_dir    = (method_ff == CODE_DIR);
            hdr_crc   = (level_ff <= LVL_1) ? crc_held_in : {buf_in[22], buf_in[21]};
            res_push                = 1'b1;
            res_data.status         = chain_bad ? ST_EXT_CHAIN : ST_OK;
            res_data.header_level   = level_ff;
            res_data.method_code    = method_ff;
            res_data.is_directory   = is_dir;
            res_data.is_compressed  = !(is_stored || is_dir);
            res_data.original_size  = {buf_in[14], buf_in[13], buf_in[12], buf_in[11]};
            res_data.stored_crc     = hdr_crc;
            res_data.member_size    = total_ff[31:0];
            if (level_ff == LVL_1) begin
               res_data.compressed_size = chain_bad ? 32'd0 : ds_ff - consumed_in;
               res_data.data_offset     = chain_bad ? 32'd0 : hs_ff + 32'd2 + consumed_in;
               res_data.os_identifier   = os_in;
            end else begin
               res_data.compressed_size = ds_ff;
               res_data.data_offset     = (level_ff == LVL_0) ? hs_ff + 32'd2 : hs_ff;
               res_data.os_identifier   = (level_ff == LVL_0) ? 8'd0 : buf_in[23];
            end
            if (check_ff && is_stored && !chain_bad) begin
               res_data.crc_result = (crc_in == hdr_crc) ? CR_MATCH : CR_MISMATCH;
            end
            first_in = 1'b0;
            if (total_ff == '0) halted_in = 1'b1;
            pos_in      = '0;
            phase_in    = 1'b0;
            level_in    = '0;
            method_in   = '0;
            hs_in       = '0;
            ds_in       = '0;
            ext_next_in = '0;
            consumed_in = '0;
            acc_in      = '0;
            crc_in      = '0;
            name_len_in = '0;
            chain_in    = CH_IDLE;
            crc_held_in = '0;
            os_in       = '0;
            known_in    = 1'b0;
            lo_in       = '0;
            hi_in       = '0;
            bound_in    = '0;
            total_in    = '0;
            l3_fixed_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         phase_ff    <= 1'b0;
         level_ff    <= '0;
         method_ff   <= '0;
         hs_ff       <= '0;
         ds_ff       <= '0;
         ext_next_ff <= '0;
         consumed_ff <= '0;
         acc_ff      <= '0;
         crc_ff      <= '0;
         first_ff    <= 1'b1;
         halted_ff   <= 1'b0;
         name_len_ff <= '0;
         chain_ff    <= CH_IDLE;
         crc_held_ff <= '0;
         os_ff       <= '0;
         known_ff    <= 1'b0;
         lo_ff       <= '0;
         hi_ff       <= '0;
         bound_ff    <= '0;
         total_ff    <= '0;
         l3_fixed_ff <= 1'b0;
         replay_ff   <= 1'b0;
         ridx_ff     <= '0;
         rlast_ff    <= '0;
         check_ff    <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         phase_ff    <= phase_in;
         level_ff    <= level_in;
         method_ff   <= method_in;
         hs_ff       <= hs_in;
         ds_ff       <= ds_in;
         ext_next_ff <= ext_next_in;
         consumed_ff <= consumed_in;
         acc_ff      <= acc_in;
         crc_ff      <= crc_in;
         first_ff    <= first_in;
         halted_ff   <= halted_in;
         name_len_ff <= name_len_in;
         chain_ff    <= chain_in;
         crc_held_ff <= crc_held_in;
         os_ff       <= os_in;
         known_ff    <= known_in;
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         bound_ff    <= bound_in;
         total_ff    <= total_in;
         l3_fixed_ff <= l3_fixed_in;
         replay_ff   <= replay_in;
         ridx_ff     <= ridx_in;
         rlast_ff    <= rlast_in;
         if (csr_write_enable) check_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("parser left the halted state");

   a_replay_quiet : assert property (@(posedge clock) disable iff (reset)
      replay_ff |-> (!in_pop && !res_push))
      else $error("transfer during header replay");

   a_phase_clean : assert property (@(posedge clock) disable iff (reset)
      !phase_ff |-> (chain_ff == CH_IDLE && !known_ff && !replay_ff))
      else $error("member state set before the header was decoded");

endmodule

[src/lha_member_header_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lha_member_header_parser
// Parses consecutive LHA members (header levels 0 to 3) from a byte stream
// and gives one result per member.
// ----------------------------------------------------------------------------
// The parser takes one archive byte per clock cycle through a four-entry input
// queue and hands results out through a two-entry result queue, so each side
// may stall on its own. The byte rate is one per cycle while the result queue
// has room, except at the start of each member: on the 21st byte the header is
// decoded and the first 20 bytes are replayed from the header buffer through
// the CRC and extended-header walker; a level 3 member replays again at its
// 28th byte. After a fatal error, or a member whose total size is zero, every
// later byte is taken and dropped.
// ----------------------------------------------------------------------------
module lha_member_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_header_level,
   output logic [23:0] rsp_method_code,
   output logic        rsp_is_directory,
   output logic        rsp_is_compressed,
   output logic [31:0] rsp_compressed_size,
   output logic [31:0] rsp_original_size,
   output logic [15:0] rsp_stored_crc,
   output logic [7:0]  rsp_os_identifier,
   output logic [31:0] rsp_data_offset,
   output logic [31:0] rsp_member_size,
   output logic [1:0]  rsp_crc_result,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import lhap_pkg::*;

   logic       q_empty, q_pop, r_full, r_push;
   logic [7:0] q_head;
   res_type    r_data, r_head;

   lhap_byte_queue u_byte_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (req_data_byte),
      .full      (req_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   lhap_member_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_empty         (q_empty),
      .in_byte          (q_head),
      .in_pop           (q_pop),
      .res_full         (r_full),
      .res_push         (r_push),
      .res_data         (r_data)
   );

   lhap_result_queue u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (r_push),
      .push_data (r_data),
      .full      (r_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (r_head)
   );

   assign rsp_status          = r_head.status;
   assign rsp_header_level    = r_head.header_level;
   assign rsp_method_code     = r_head.method_code;
   assign rsp_is_directory    = r_head.is_directory;
   assign rsp_is_compressed   = r_head.is_compressed;
   assign rsp_compressed_size = r_head.compressed_size;
   assign rsp_original_size   = r_head.original_size;
   assign rsp_stored_crc      = r_head.stored_crc;
   assign rsp_os_identifier   = r_head.os_identifier;
   assign rsp_data_offset     = r_head.data_offset;
   assign rsp_member_size     = r_head.member_size;
   assign rsp_crc_result      = r_head.crc_result;

endmodule

[tb/sv/lha_member_header_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lha_member_header_parser_tb
// Streams generated LHA members of all four header levels through the parser
// and checks every member result against a byte-level model of the parser.
// Both handshakes idle at random, the CRC check setting changes between
// phases, and the run ends on a truncated member or one that stops the parser.
// ----------------------------------------------------------------------------
module lha_member_header_parser_tb;
   import lhap_pkg::*;

   localparam logic [23:0] CODE_LH5   = 24'h6c6835;
   localparam int          HOLD_LEN   = 400;
   localparam int          SETTLE     = 80;
   localparam int          NUM_PHASES = 8;
   localparam int          BYTE_GOAL  = 1550;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_data_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [2:0]  rsp_status;
   logic [1:0]  rsp_header_level;
   logic [23:0] rsp_method_code;
   logic        rsp_is_directory;
   logic        rsp_is_compressed;
   logic [31:0] rsp_compressed_size;
   logic [31:0] rsp_original_size;
   logic [15:0] rsp_stored_crc;
   logic [7:0]  rsp_os_identifier;
   logic [31:0] rsp_data_offset;
   logic [31:0] rsp_member_size;
   logic [1:0]  rsp_crc_result;
   logic        csr_write_enable;
   logic        csr_write_data;

   lha_member_header_parser i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_data_byte       (req_data_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_status          (rsp_status),
      .rsp_header_level    (rsp_header_level),
      .rsp_method_code     (rsp_method_code),
      .rsp_is_directory    (rsp_is_directory),
      .rsp_is_compressed   (rsp_is_compressed),
      .rsp_compressed_size (rsp_compressed_size),
      .rsp_original_size   (rsp_original_size),
      .rsp_stored_crc      (rsp_stored_crc),
      .rsp_os_identifier   (rsp_os_identifier),
      .rsp_data_offset     (rsp_data_offset),
      .rsp_member_size     (rsp_member_size),
      .rsp_crc_result      (rsp_crc_result),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   // Archive bytes waiting to be offered, and member results still owed.
   logic [7:0] pending_bytes[$];
   res_type    member_results[$];

   int bytes_queued   = 0;
   int results_seen   = 0;
   int mismatches     = 0;
   int send_gap_max   = 17;
   int recv_gap_max   = 17;
   int send_wait      = 0;
   int pop_wait       = 0;
   int hold_left      = 0;
   int holds_asked    = 0;
   int holds_done     = 0;
   bit byte_taken     = 0;
   bit result_taken   = 0;

   // Parser model state.
   longint unsigned mem_pos, ext_next, data_lo, data_hi;
   logic [7:0]      front_buf[FRONT_BYTES];
   bit              in_body, data_known, first_member, halted, crc_check_on;
   logic [1:0]      level_q;
   logic [23:0]     method_q;
   logic [31:0]     hdr_size, data_size, ext_used;
   logic [7:0]      size_low, name_len, os_byte;
   logic [15:0]     data_crc, hdr_crc_q;
   chain_type       chain_q;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [15:0] arc_crc_update(input logic [15:0] crc,
                                                  input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   function automatic logic [31:0] front_le(input int at, input int n);
      logic [31:0] v;
      v = '0;
      for (int i = 0; i < n; i++) v |= 32'(front_buf[(at + i) % FRONT_BYTES]) << (8 * i);
      return v;
   endfunction

   task automatic start_member();
      mem_pos    = 0;
      in_body    = 0;
      level_q    = LVL_0;
      method_q   = '0;
      hdr_size   = '0;
      data_size  = '0;
      ext_next   = 0;
      ext_used   = '0;
      size_low   = '0;
      data_crc   = '0;
      name_len   = '0;
      chain_q    = CH_IDLE;
      hdr_crc_q  = '0;
      os_byte    = '0;
      data_known = 0;
      data_lo    = 0;
      data_hi    = 0;
   endtask

   task automatic post_fatal(input logic [2:0] st);
      res_type r;
      r = '0;
      r.status = st;
      if (st >= ST_BAD_LEVEL) r.method_code = method_q;
      if (st == ST_BAD_WORD) r.header_level = LVL_3;
      member_results.push_back(r);
      halted = 1;
   endtask

   task automatic walk_ext_chain(input longint unsigned q, input logic [7:0] b);
      longint unsigned sz, pos, start, bound;
      if (chain_q != CH_WALK) return;
      if (q == ext_next) begin
         size_low = b;
      end else if (q == ext_next + 1) begin
         sz    = {b, size_low};
         pos   = q + 1;
         start = longint'(hdr_size) + 2;
         bound = start + data_size;
         if (sz == 0) begin
            chain_q    = CH_DONE;
            ext_used   = 32'(pos - start);
            data_known = 1;
            data_lo    = pos;
            data_hi    = bound;
         end else if (sz < 2 || pos + sz > bound) begin
            chain_q = CH_ERR;
         end else begin
            ext_next = pos + sz - 2;
         end
      end
   endtask

   task automatic body_byte(input longint unsigned q, input logic [7:0] b);
      if (level_q == LVL_3 && q == L3_FIX_BYTE) begin
         hdr_size   = front_le(24, 4);
         data_known = 1;
         data_lo    = hdr_size;
         data_hi    = data_lo + data_size;
         // Header bytes already gone by that fall inside the data still count.
         for (longint unsigned r = data_lo; r < L3_FIX_BYTE && r < data_hi; r++)
            data_crc = arc_crc_update(data_crc, front_buf[r]);
      end
      if (data_known && q >= data_lo && q < data_hi) data_crc = arc_crc_update(data_crc, b);
      if (level_q <= LVL_1) begin
         if (q == 21) name_len = b;
         else if (q > 21) begin
            if (q == 22 + name_len) hdr_crc_q = {8'h00, b};
            else if (q == 23 + name_len) hdr_crc_q[15:8] = b;
            else if (level_q == LVL_1 && q == 24 + name_len) os_byte = b;
         end
      end
      if (level_q == LVL_1) walk_ext_chain(q, b);
   endtask

   task automatic parse_byte(input logic [7:0] b);
      longint unsigned q, total, last_hdr, off;
      res_type r;
      bit chain_bad;
      if (halted) return;
      q = mem_pos;
      if (q < FRONT_BYTES) front_buf[q] = b;
      if (!in_body) begin
         if (q < MIN_MEMBER - 1) begin
            mem_pos++;
            return;
         end
         if (front_buf[2] != DELIM || front_buf[6] != DELIM) begin
            if (first_member) post_fatal(ST_NOT_LHA);
            else halted = 1;
            return;
         end
         method_q = {front_buf[3], front_buf[4], front_buf[5]};
         if (b > 3) begin
            post_fatal(ST_BAD_LEVEL);
            return;
         end
         level_q = b[1:0];
         if (level_q == LVL_3 && front_le(0, 2) != 4) begin
            post_fatal(ST_BAD_WORD);
            return;
         end
         data_size = front_le(7, 4);
         if (level_q <= LVL_1) hdr_size = front_buf[0];
         if (level_q == LVL_2) hdr_size = front_le(0, 2);
         if (level_q == LVL_0 || level_q == LVL_2) begin
            data_known = 1;
            data_lo    = (level_q == LVL_0) ? longint'(hdr_size) + 2 : hdr_size;
            data_hi    = data_lo + data_size;
         end
         if (level_q == LVL_1) begin
            chain_q  = CH_WALK;
            ext_next = hdr_size;
         end
         in_body = 1;
         for (int i = 0; i < MIN_MEMBER - 1; i++) body_byte(i, front_buf[i]);
      end
      body_byte(q, b);

      total = longint'(hdr_size) + data_size + ((level_q <= LVL_1) ? 2 : 0);
      case (level_q)
         LVL_0:   last_hdr = 23 + name_len;
         LVL_1:   last_hdr = 24 + name_len;
         LVL_2:   last_hdr = 23;
         default: last_hdr = L3_FIX_BYTE;
      endcase
      if (q >= last_hdr && q + 1 >= total && (level_q != LVL_1 || chain_q != CH_WALK)) begin
         chain_bad       = (level_q == LVL_1 && chain_q != CH_DONE);
         r               = '0;
         r.status        = chain_bad ? ST_EXT_CHAIN : ST_OK;
         r.header_level  = level_q;
         r.method_code   = method_q;
         r.is_directory  = (method_q == CODE_DIR);
         r.is_compressed = !(method_q == CODE_DIR || method_q == CODE_STORED);
         if (level_q == LVL_1) begin
            r.compressed_size = chain_bad ? '0 : data_size - ext_used;
            off = chain_bad ? 0 : longint'(hdr_size) + 2 + ext_used;
         end else begin
            r.compressed_size = data_size;
            off = (level_q == LVL_0) ? longint'(hdr_size) + 2 : hdr_size;
         end
         r.original_size = front_le(11, 4);
         r.stored_crc    = (level_q <= LVL_1) ? hdr_crc_q : front_le(21, 2);
         r.os_identifier = (level_q == LVL_0) ? 8'h00 :
                           (level_q == LVL_1) ? os_byte : front_buf[23];
         r.data_offset   = off[31:0];
         r.member_size   = total[31:0];
         if (crc_check_on && method_q == CODE_STORED && !chain_bad)
            r.crc_result = (data_crc == r.stored_crc) ? CR_MATCH : CR_MISMATCH;
         else
            r.crc_result = CR_NONE;
         member_results.push_back(r);
         first_member = 0;
         start_member();
         if (total == 0) halted = 1;
         return;
      end
      mem_pos++;
   endtask

   function automatic string show(input res_type r);
      return $sformatf({"st=%0d lvl=%0d meth=%h dir=%b cmp=%b csz=%h osz=%h crc=%h",
                        " os=%h off=%h msz=%h crs=%0d"},
                       r.status, r.header_level, r.method_code, r.is_directory,
                       r.is_compressed, r.compressed_size, r.original_size, r.stored_crc,
                       r.os_identifier, r.data_offset, r.member_size, r.crc_result);
   endfunction

   // Sender: holds a byte until its transfer, then waits its drawn gap.
   always @(negedge clock) begin
      if (reset) begin
         req_push      <= 1'b0;
         req_data_byte <= 8'h00;
      end else if (req_push && !byte_taken) begin
         req_push <= 1'b1;
      end else if (send_wait > 0) begin
         req_push  <= 1'b0;
         send_wait <= send_wait - 1;
      end else if (pending_bytes.size() > 0) begin
         req_data_byte <= pending_bytes.pop_front();
         req_push      <= 1'b1;
         send_wait     <= $urandom_range(0, send_gap_max);
      end else begin
         req_push <= 1'b0;
      end
   end

   // Receiver: random gaps after each transfer, plus long hold-offs on request.
   always @(negedge clock) begin
      int w;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_pop   <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_done < holds_asked) begin
         rsp_pop    <= 1'b0;
         hold_left  <= HOLD_LEN;
         holds_done <= holds_done + 1;
      end else if (pop_wait > 0) begin
         rsp_pop  <= 1'b0;
         pop_wait <= pop_wait - 1;
      end else if (result_taken) begin
         w = $urandom_range(0, recv_gap_max);
         rsp_pop <= (w == 0);
         if (w != 0) pop_wait <= w - 1;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      res_type got, want;
      byte_taken   <= !reset && req_push && !req_full;
      result_taken <= !reset && rsp_pop && !rsp_empty;
      if (!reset) begin
         if (req_push && !req_full) parse_byte(req_data_byte);
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_status, rsp_header_level, rsp_method_code, rsp_is_directory,
                    rsp_is_compressed, rsp_compressed_size, rsp_original_size,
                    rsp_stored_crc, rsp_os_identifier, rsp_data_offset,
                    rsp_member_size, rsp_crc_result};
            results_seen++;
            if (member_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result: %s", show(got));
            end else begin
               want = member_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Result mismatch at %0t", $realtime);
                     $display("  expected %s", show(want));
                     $display("  actual   %s", show(got));
                  end
               end
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_push || member_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_crc_check(input bit on);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= on;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      crc_check_on = on;
   endtask

   task automatic queue_bytes(input logic [7:0] m[]);
      foreach (m[i]) pending_bytes.push_back(m[i]);
      bytes_queued += m.size();
   endtask

   // shape: 0 well formed, 1 wrong header CRC, 2 header size overlapping the
   // fixed header (levels 0 and 2), 3 broken extended-header chain (level 1).
   task automatic queue_member(input logic [1:0] lvl, input int shape,
                               input logic [23:0] code);
      logic [7:0]  m[];
      logic [31:0] dsz;
      logic [15:0] crc;
      int n, h, d, len, lo, pos, ext_sum, crc_at;
      int ext_sizes[$];
      n       = $urandom_range(0, 8);
      d       = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 20);
      ext_sum = 0;
      case (lvl)
         LVL_0: begin
            h   = (shape == 2) ? $urandom_range(0, 30) : 22 + n;
            len = (2 + h + d > 24 + n) ? 2 + h + d : 24 + n;
            lo  = 2 + h;
         end
         LVL_1: begin
            repeat ($urandom_range(0, 3)) ext_sizes.push_back($urandom_range(3, 6));
            foreach (ext_sizes[i]) ext_sum += ext_sizes[i];
            h   = 25 + n;
            len = 2 + h + ext_sum + d;
            lo  = h + 2 + ext_sum;
         end
         LVL_2: begin
            h   = (shape == 2) ? $urandom_range(1, 30) : $urandom_range(26, 40);
            len = (h + d > 24) ? h + d : 24;
            lo  = h;
         end
         default: begin
            h   = $urandom_range(28, 40);
            len = h + d;
            lo  = h;
         end
      endcase
      m = new[len];
      foreach (m[i]) m[i] = $urandom;
      dsz = (lvl == LVL_1) ? ext_sum + d : d;
      if (lvl == LVL_3) begin
         {m[1], m[0]} = 16'd4;
         {m[27], m[26], m[25], m[24]} = h;
      end else if (lvl == LVL_2) begin
         {m[1], m[0]} = h[15:0];
      end else begin
         m[0]  = h[7:0];
         m[21] = n[7:0];
      end
      m[2] = DELIM;
      {m[3], m[4], m[5]} = code;
      m[6] = DELIM;
      {m[10], m[9], m[8], m[7]} = dsz;
      m[20] = {6'd0, lvl};
      if (lvl == LVL_1) begin
         pos = h;
         foreach (ext_sizes[i]) begin
            {m[pos + 1], m[pos]} = ext_sizes[i];
            pos += ext_sizes[i];
         end
         {m[pos + 1], m[pos]} = 16'd0;
         if (shape == 3) {m[h + 1], m[h]} = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'd250;
      end
      if (shape != 2) begin
         crc = '0;
         for (int i = lo; i < lo + d; i++) crc = arc_crc_update(crc, m[i]);
         if (shape == 1) crc ^= 16'h0001;
         crc_at = (lvl <= LVL_1) ? 22 + n : 21;
         {m[crc_at + 1], m[crc_at]} = crc;
      end
      queue_bytes(m);
   endtask

   function automatic logic [23:0] pick_code();
      case ($urandom_range(0, 3))
         0:       return CODE_STORED;
         1:       return CODE_DIR;
         2:       return CODE_LH5;
         default: return 24'($urandom);
      endcase
   endfunction

   // The stream ends on a short member or on a member that stops the parser.
   task automatic queue_ending(input int kind);
      logic [7:0] m[];
      m = new[(kind == 0) ? $urandom_range(1, 20) : 24];
      foreach (m[i]) m[i] = $urandom;
      if (kind != 0) begin
         m[2] = DELIM;
         m[6] = DELIM;
         case (kind)
            1: m[20] = $urandom_range(4, 255);
            2: begin
               m[20] = 8'd3;
               m[1]  = $urandom_range(1, 255);
            end
            3: begin
               m[20] = 8'd2;
               {m[1], m[0]} = 16'd0;
               {m[10], m[9], m[8], m[7]} = 32'd0;
            end
            default: m[2] = DELIM ^ 8'h01;
         endcase
      end
      queue_bytes(m);
      if (kind != 0) begin
         m = new[10];
         foreach (m[i]) m[i] = $urandom;
         queue_bytes(m);
      end
   endtask

   initial begin
      bit crc_plan[NUM_PHASES] = '{1, 0, 1, 1, 0, 1, 0, 1};
      logic [1:0] lvl;
      int shape;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      crc_check_on     = 0;
      first_member     = 1;
      halted           = 0;
      foreach (front_buf[i]) front_buf[i] = 8'h00;
      start_member();
      @(negedge reset);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         write_crc_check(crc_plan[p]);
         send_gap_max = (p % 3 == 1) ? 0 : 17;
         recv_gap_max = (p % 3 == 2) ? 0 : 17;
         if (p == 3) holds_asked++;
         if (p < 2) begin
            queue_member(LVL_0, 0, CODE_STORED);
            queue_member(LVL_0, 1, CODE_STORED);
            queue_member(LVL_1, 0, CODE_STORED);
            queue_member(LVL_1, 3, CODE_LH5);
            queue_member(LVL_2, 0, CODE_DIR);
            queue_member(LVL_2, 2, CODE_STORED);
            queue_member(LVL_0, 2, CODE_STORED);
            queue_member(LVL_3, 0, CODE_STORED);
            queue_member(LVL_3, 1, CODE_LH5);
         end
         while (bytes_queued < BYTE_GOAL * (p + 1) / NUM_PHASES) begin
            lvl   = $urandom_range(0, 3);
            shape = $urandom_range(0, 9);
            shape = (shape == 6) ? 1 : (shape == 7) ? 2 : (shape == 8) ? 3 : 0;
            if (shape == 2 && (lvl == LVL_1 || lvl == LVL_3)) shape = 0;
            if (shape == 3 && lvl != LVL_1) shape = 0;
            queue_member(lvl, shape, pick_code());
         end
      end
      queue_ending($urandom_range(0, 4));
      wait_drained();
      repeat (100) @(posedge clock);

      $display("Sent %0d archive bytes over %0d phases with the CRC check toggled,",
               bytes_queued, NUM_PHASES);
      $display("checked %0d member results covering all header levels.", results_seen);
      if (mismatches == 0 && member_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
